>>> hw/rtl/gac_pkg.sv
// gas alarm controller package: widths, reset values, register indexes and
// the status and result structs; the package is shared by the control, averager and top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gac_pkg;

  localparam int unsigned AdcW      = 10;
  localparam int unsigned WarmW     = 12;
  localparam int unsigned BurstW    = 6;
  localparam int unsigned SumW      = 17;
  localparam int unsigned TallyW    = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;

  localparam int unsigned AverageBlockDefault = 100;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegAlarmThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWarmupLast     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBurstToggles   = 2'd2;

  localparam logic [AdcW-1:0]   ThresholdReset  = 10'd364;
  localparam logic [WarmW-1:0]  WarmupLastReset = 12'd180;
  localparam logic [BurstW-1:0] BurstReset      = 6'd9;

  // command codes
  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick   = 1'b1;

  // drive levels and flags owned by the tick controller
  typedef struct packed {
    logic buzzer;
    logic red;
    logic green;
    logic white;
    logic blue;
    logic warmed_up;
    logic alarm_active;
  } gac_status_t;

  typedef struct packed {
    gac_status_t           status;
    logic [AdcW-1:0]       average;
  } gac_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/gac_avg.sv
// block averager for adc samples: sums a block of samples and divides by the
// block length through a constant reciprocal multiply
// depends on gac_pkg
`timescale 1ns / 1ps
`default_nettype none

module gac_avg #(
  parameter int unsigned AverageBlock = gac_pkg::AverageBlockDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      sample_i,
  input  wire logic [gac_pkg::AdcW-1:0]  code_i,
  output logic      [gac_pkg::AdcW-1:0]  average_q_o,
  output logic      [gac_pkg::AdcW-1:0]  average_d_o
);

  localparam int unsigned SumW   = gac_pkg::SumW;
  localparam int unsigned TallyW = gac_pkg::TallyW;
  localparam int unsigned AdcW   = gac_pkg::AdcW;
  // exact floor division for any SumW-bit dividend
  localparam int unsigned Shift  = SumW + $clog2(AverageBlock);
  localparam longint unsigned RecipL =
    ((64'd1 << Shift) + AverageBlock - 1) / AverageBlock;
  localparam int unsigned RecipW = SumW + 1;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
  localparam logic [TallyW-1:0] BlockCnt = TallyW'(AverageBlock);
  localparam int unsigned ProdW = SumW + RecipW;

  logic [SumW-1:0]   sum_q, sum_d, sum_add;
  logic [TallyW-1:0] tally_q, tally_d, tally_add;
  logic [AdcW-1:0]   avg_q, avg_d;
  logic [ProdW-1:0]  prod;

  always_comb begin
    sum_add   = sum_q + SumW'(code_i);
    tally_add = tally_q + TallyW'(1);
    prod      = ProdW'(sum_add) * ProdW'(Recip);
    sum_d     = sum_q;
    tally_d   = tally_q;
    avg_d     = avg_q;
    if (sample_i) begin
      sum_d   = sum_add;
      tally_d = tally_add;
      if (tally_add >= BlockCnt) begin
        avg_d   = prod[Shift +: AdcW];
        sum_d   = '0;
        tally_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      tally_q <= '0;
      avg_q   <= '0;
    end else begin
      sum_q   <= sum_d;
      tally_q <= tally_d;
      avg_q   <= avg_d;
    end
  end

  assign average_q_o = avg_q;
  assign average_d_o = avg_d;

endmodule

`default_nettype wire

>>> hw/rtl/gac_ctrl.sv
// tick controller: warm-up counter, alarm decision and burst sequencing of
// the led and buzzer drive levels
// depends on gac_pkg
`timescale 1ns / 1ps
`default_nettype none

module gac_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic                          adapter_i,
  input  wire logic [gac_pkg::AdcW-1:0]      average_i,
  input  wire logic [gac_pkg::AdcW-1:0]      threshold_i,
  input  wire logic [gac_pkg::WarmW-1:0]     warmup_last_i,
  input  wire logic [gac_pkg::BurstW-1:0]    burst_toggles_i,
  output gac_pkg::gac_status_t               status_d_o
);

  gac_pkg::gac_status_t              stat_q, stat_d;
  logic [gac_pkg::WarmW-1:0]         warm_cnt_q, warm_cnt_d;
  logic [gac_pkg::BurstW-1:0]        burst_cnt_q, burst_cnt_d, burst_next;
  logic                              do_toggle;

  always_comb begin
    stat_d      = stat_q;
    warm_cnt_d  = warm_cnt_q;
    burst_cnt_d = burst_cnt_q;
    do_toggle   = 1'b0;
    burst_next  = '0;
    if (tick_i) begin
      if (!stat_q.warmed_up) begin
        stat_d.green = ~stat_q.green;
        if (warm_cnt_q >= warmup_last_i) begin
          stat_d.warmed_up = 1'b1;
        end else begin
          warm_cnt_d = warm_cnt_q + gac_pkg::WarmW'(1);
        end
      end else if (stat_q.alarm_active) begin
        do_toggle  = 1'b1;
        burst_next = burst_cnt_q + gac_pkg::BurstW'(1);
      end else if (average_i > threshold_i) begin
        // burst starts and its first toggle lands on this tick
        stat_d.white        = 1'b0;
        stat_d.blue         = 1'b0;
        stat_d.alarm_active = 1'b1;
        do_toggle           = 1'b1;
        burst_next          = gac_pkg::BurstW'(1);
      end else begin
        stat_d.buzzer = 1'b0;
        stat_d.red    = 1'b0;
        stat_d.green  = 1'b0;
        stat_d.white  = adapter_i;
        stat_d.blue   = ~adapter_i;
      end
      if (do_toggle) begin
        stat_d.red    = ~stat_q.red;
        stat_d.buzzer = ~stat_q.buzzer;
        burst_cnt_d   = burst_next;
        if (burst_next >= burst_toggles_i) begin
          stat_d.alarm_active = 1'b0;
          burst_cnt_d         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q      <= '0;
      warm_cnt_q  <= '0;
      burst_cnt_q <= '0;
    end else begin
      stat_q      <= stat_d;
      warm_cnt_q  <= warm_cnt_d;
      burst_cnt_q <= burst_cnt_d;
    end
  end

  assign status_d_o = stat_d;

endmodule

`default_nettype wire

>>> hw/rtl/gas_alarm_controller_top.sv
// gas alarm controller top level: input register, configuration registers,
// result register and the averager and tick controller between them
// depends on gac_pkg, gac_avg, gac_ctrl
//
// usage: each input item is an event, an adc sample (command 0) or a
// one-second tick (command 1), with the adapter pin level. every item gives
// exactly one result item with the led and buzzer levels, the latest block
// average of the samples, and the warm-up and alarm flags after that event.
// an item accepted at one clock edge waits in the input register until the
// result slot is free, and is processed at the edge where its result is
// loaded into the output register. one item per cycle is sustained while
// out_ready_i is high; the input and output registers each hold one item, so
// on a receiver stall the block takes at most one more item, then drops in_ready_o.
// configuration writes (index 0 threshold, 1 last warm-up tick, 2 burst
// toggles) are always ready and take effect on the next processed item;
// write them only while no item is in flight. reset (rst_ni low) clears both
// valid bits and the averager and controller state and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module gas_alarm_controller_top #(
  parameter int unsigned AverageBlock = gac_pkg::AverageBlockDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            command_i,
  input  wire logic [gac_pkg::AdcW-1:0]        adc_sample_i,
  input  wire logic                            adapter_present_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 buzzer_on_o,
  output logic                                 red_led_o,
  output logic                                 green_led_o,
  output logic                                 white_led_o,
  output logic                                 blue_led_o,
  output logic      [gac_pkg::AdcW-1:0]        sensor_average_o,
  output logic                                 warmed_up_o,
  output logic                                 alarm_active_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [gac_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [gac_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic                              in_vld_q, in_vld_d;
  logic                              cmd_q;
  logic [gac_pkg::AdcW-1:0]          code_q;
  logic                              adapter_q;
  logic                              out_vld_q, out_vld_d;
  gac_pkg::gac_result_t              res_q;
  logic                              proc, in_accept;

  logic [gac_pkg::AdcW-1:0]          thr_q;
  logic [gac_pkg::WarmW-1:0]         warm_last_q;
  logic [gac_pkg::BurstW-1:0]        toggles_q;

  logic [gac_pkg::AdcW-1:0]          avg_cur, avg_next;
  gac_pkg::gac_status_t              stat_next;

  // item in the input register moves on when the result slot frees up
  assign proc       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || proc;
  assign in_accept  = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (proc) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q     <= command_i;
      code_q    <= adc_sample_i;
      adapter_q <= adapter_present_i;
    end
    if (proc) begin
      res_q.status  <= stat_next;
      res_q.average <= avg_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= gac_pkg::ThresholdReset;
      warm_last_q <= gac_pkg::WarmupLastReset;
      toggles_q   <= gac_pkg::BurstReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gac_pkg::RegAlarmThreshold: thr_q       <= cfg_data_i[gac_pkg::AdcW-1:0];
        gac_pkg::RegWarmupLast:     warm_last_q <= cfg_data_i[gac_pkg::WarmW-1:0];
        gac_pkg::RegBurstToggles:   toggles_q   <= cfg_data_i[gac_pkg::BurstW-1:0];
        default: ;
      endcase
    end
  end

  gac_avg #(
    .AverageBlock(AverageBlock)
  ) u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (proc && (cmd_q == gac_pkg::CmdSample)),
    .code_i      (code_q),
    .average_q_o (avg_cur),
    .average_d_o (avg_next)
  );

  gac_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (proc && (cmd_q == gac_pkg::CmdTick)),
    .adapter_i       (adapter_q),
    .average_i       (avg_cur),
    .threshold_i     (thr_q),
    .warmup_last_i   (warm_last_q),
    .burst_toggles_i (toggles_q),
    .status_d_o      (stat_next)
  );

  assign out_valid_o      = out_vld_q;
  assign buzzer_on_o      = res_q.status.buzzer;
  assign red_led_o        = res_q.status.red;
  assign green_led_o      = res_q.status.green;
  assign white_led_o      = res_q.status.white;
  assign blue_led_o       = res_q.status.blue;
  assign sensor_average_o = res_q.average;
  assign warmed_up_o      = res_q.status.warmed_up;
  assign alarm_active_o   = res_q.status.alarm_active;

  // no burst before warm-up has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.status.warmed_up |-> !res_q.status.alarm_active)
    else $error("alarm active during warm-up");

  // white and blue stay dark for the whole burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status.alarm_active |-> !res_q.status.white && !res_q.status.blue)
    else $error("white or blue lit during alarm burst");

  // a processed item always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_vld_q)
    else $error("processed item lost");

  // a waiting input item keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !proc |=> in_vld_q && $stable(cmd_q) && $stable(code_q) && $stable(adapter_q))
    else $error("held input item changed");

endmodule

`default_nettype wire
